### rtl/stp_pkg.sv
`timescale 1ns / 1ps
// stp_pkg: constants and types shared by the stereographic projection block
// no dependencies

package stp_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int OUT_BITS          = 48;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ZERO   = 2'd1,
    ST_POLE   = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

endpackage

### rtl/stp_in_if.sv
`timescale 1ns / 1ps
// stp_in_if: input word channel carrying one 3-D point
// depends on stp_pkg

interface stp_in_if
  import stp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;

  modport source (output valid, output px, output py, output pz, input ready);
  modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

### rtl/stp_out_if.sv
`timescale 1ns / 1ps
// stp_out_if: result word channel carrying the projected point and status
// depends on stp_pkg

interface stp_out_if
  import stp_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] plane_x;
  logic signed [OUT_BITS-1:0] plane_y;
  status_t                    status;

  modport source (output valid, output plane_x, output plane_y, output status, input ready);
  modport sink   (input valid, input plane_x, input plane_y, input status, output ready);
endinterface

### rtl/stereographic_projection_core.sv
`timescale 1ns / 1ps
// Stages: magnitudes, squares, radicand, square root, denominator, numerator, divide and
// output register, one root bit and one quotient bit per stage; NW = 2*COORD_BITS + 8 + OUT_FRAC_BITS.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: synchronous active-low rst_n clears every stage valid bit; data is not reset.
// stereographic_projection_core: pipelined norm, square root, multiply and divide
// depends on stp_pkg, stp_in_if, stp_out_if

module stereographic_projection_core
  import stp_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  stp_in_if.sink    in_if,
  stp_out_if.source out_if
);

  localparam int C    = COORD_BITS;
  localparam int F    = OUT_FRAC_BITS;
  localparam int SW   = 2 * C;
  localparam int RW   = SW + 16;
  localparam int RB   = C + 8;
  localparam int REMW = RB + 2;
  localparam int DW   = C + 9;
  localparam int NW   = C + RB + F;
  localparam int XW   = (NW > OUT_BITS ? NW : OUT_BITS) + 1;

  typedef struct packed {
    logic [C-1:0] mx;
    logic [C-1:0] my;
    logic [C-1:0] mz;
    logic         nx;
    logic         ny;
    logic         nz;
    logic         zero;
    logic         pole;
  } side_t;

  logic en;
  logic out_v_r;

  // whole pipeline moves unless the output word is stuck
  assign en          = !out_v_r || out_if.ready;
  assign in_if.ready = en;

  // stage 0: magnitudes and signs
  side_t        s0_nxt, s0_r;
  logic         v0_r;
  logic [C-1:0] ux, uy, uz;

  always_comb begin
    ux = in_if.px;
    uy = in_if.py;
    uz = in_if.pz;
    s0_nxt.nx   = ux[C-1];
    s0_nxt.ny   = uy[C-1];
    s0_nxt.nz   = uz[C-1];
    s0_nxt.mx   = ux[C-1] ? (~ux + 1'b1) : ux;
    s0_nxt.my   = uy[C-1] ? (~uy + 1'b1) : uy;
    s0_nxt.mz   = uz[C-1] ? (~uz + 1'b1) : uz;
    s0_nxt.zero = (ux == '0) && (uy == '0) && (uz == '0);
    s0_nxt.pole = (ux == '0) && (uy == '0) && !uz[C-1];
  end

  // stage 1: squares
  side_t         s1_r;
  logic          v1_r;
  logic [SW-1:0] sqx_r, sqy_r, sqz_r;

  // stage 2: sum of squares as radicand with 16 extra fraction bits
  side_t         s2_r;
  logic          v2_r;
  logic [RW-1:0] rad2_r;
  logic [SW+1:0] sum_w;

  assign sum_w = {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_if.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r   <= s0_nxt;
      s1_r   <= s0_r;
      sqx_r  <= s0_r.mx * s0_r.mx;
      sqy_r  <= s0_r.my * s0_r.my;
      sqz_r  <= s0_r.mz * s0_r.mz;
      s2_r   <= s1_r;
      rad2_r <= {sum_w[SW-1:0], 16'd0};
    end
  end

  // square root: one root bit per stage
  logic [RW-1:0]   sq_rad  [0:RB];
  logic [REMW-1:0] sq_rem  [0:RB];
  logic [RB-1:0]   sq_root [0:RB];
  side_t           sq_side [0:RB];
  logic            sq_v    [0:RB];

  assign sq_rad[0]  = rad2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s2_r;
  assign sq_v[0]    = v2_r;

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [REMW-1:0] rem_w, trial_w;
    logic [RW-1:0]   rad_r;
    logic [REMW-1:0] rem_r;
    logic [RB-1:0]   root_r;
    side_t           side_r;
    logic            v_r;

    assign rem_w   = {sq_rem[k][REMW-3:0], sq_rad[k][RW-1 -: 2]};
    assign trial_w = {sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= {sq_rad[k][RW-3:0], 2'b00};
        side_r <= sq_side[k];
        if (rem_w >= trial_w) begin
          rem_r  <= rem_w - trial_w;
          root_r <= {sq_root[k][RB-2:0], 1'b1};
        end else begin
          rem_r  <= rem_w;
          root_r <= {sq_root[k][RB-2:0], 1'b0};
        end
      end
    end

    assign sq_rad[k+1]  = rad_r;
    assign sq_rem[k+1]  = rem_r;
    assign sq_root[k+1] = root_r;
    assign sq_side[k+1] = side_r;
    assign sq_v[k+1]    = v_r;
  end

  // denominator stage: d = r8 - pz * 2^8, floored at zero
  logic [RB-1:0] zs_w;
  logic [DW-1:0] d_nxt, d_r;
  logic [RB-1:0] r8_r;
  side_t         sd_r;
  logic          vd_r;

  assign zs_w = {sq_side[RB].mz, 8'd0};

  always_comb begin
    if (sq_side[RB].nz) begin
      d_nxt = {1'b0, sq_root[RB]} + {1'b0, zs_w};
    end else if (sq_root[RB] >= zs_w) begin
      d_nxt = {1'b0, sq_root[RB] - zs_w};
    end else begin
      d_nxt = '0;
    end
  end

  // numerator stage: |p| * r8 * 2^F
  logic [C+RB-1:0] prodx_w, prody_w;
  logic [NW-1:0]   numx_r, numy_r;
  logic [DW-1:0]   dm_r;
  side_t           sm_r;
  logic            vm_r;

  assign prodx_w = sd_r.mx * r8_r;
  assign prody_w = sd_r.my * r8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vm_r <= 1'b0;
    end else if (en) begin
      vd_r <= sq_v[RB];
      vm_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      r8_r   <= sq_root[RB];
      sd_r   <= sq_side[RB];
      numx_r <= {prodx_w, {F{1'b0}}};
      numy_r <= {prody_w, {F{1'b0}}};
      dm_r   <= d_r;
      sm_r   <= sd_r;
    end
  end

  // restoring division: one quotient bit per stage for both components
  logic [NW-1:0] dv_nx [0:NW];
  logic [NW-1:0] dv_ny [0:NW];
  logic [DW:0]   dv_rx [0:NW];
  logic [DW:0]   dv_ry [0:NW];
  logic [NW-1:0] dv_qx [0:NW];
  logic [NW-1:0] dv_qy [0:NW];
  logic [DW-1:0] dv_d  [0:NW];
  side_t         dv_s  [0:NW];
  logic          dv_v  [0:NW];

  assign dv_nx[0] = numx_r;
  assign dv_ny[0] = numy_r;
  assign dv_rx[0] = '0;
  assign dv_ry[0] = '0;
  assign dv_qx[0] = '0;
  assign dv_qy[0] = '0;
  assign dv_d[0]  = dm_r;
  assign dv_s[0]  = sm_r;
  assign dv_v[0]  = vm_r;

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DW:0]   tx_w, ty_w, dd_w;
    logic [NW-1:0] nx_r, ny_r, qx_r, qy_r;
    logic [DW:0]   rx_r, ry_r;
    logic [DW-1:0] d_st_r;
    side_t         side_r;
    logic          v_r;

    assign tx_w = {dv_rx[j][DW-1:0], dv_nx[j][NW-1]};
    assign ty_w = {dv_ry[j][DW-1:0], dv_ny[j][NW-1]};
    assign dd_w = {1'b0, dv_d[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r   <= dv_nx[j] << 1;
        ny_r   <= dv_ny[j] << 1;
        d_st_r <= dv_d[j];
        side_r <= dv_s[j];
        if (tx_w >= dd_w) begin
          rx_r <= tx_w - dd_w;
          qx_r <= {dv_qx[j][NW-2:0], 1'b1};
        end else begin
          rx_r <= tx_w;
          qx_r <= {dv_qx[j][NW-2:0], 1'b0};
        end
        if (ty_w >= dd_w) begin
          ry_r <= ty_w - dd_w;
          qy_r <= {dv_qy[j][NW-2:0], 1'b1};
        end else begin
          ry_r <= ty_w;
          qy_r <= {dv_qy[j][NW-2:0], 1'b0};
        end
      end
    end

    assign dv_nx[j+1] = nx_r;
    assign dv_ny[j+1] = ny_r;
    assign dv_rx[j+1] = rx_r;
    assign dv_ry[j+1] = ry_r;
    assign dv_qx[j+1] = qx_r;
    assign dv_qy[j+1] = qy_r;
    assign dv_d[j+1]  = d_st_r;
    assign dv_s[j+1]  = side_r;
    assign dv_v[j+1]  = v_r;
  end

  // output stage: saturation, sign and status
  side_t         fs;
  logic [XW-1:0] qx_ext, qy_ext, limx, limy, selx, sely;
  logic          satx, saty;
  logic [OUT_BITS-1:0] px_nxt, py_nxt, plane_x_r, plane_y_r;
  status_t       st_nxt, status_r;

  assign fs     = dv_s[NW];
  assign qx_ext = XW'(dv_qx[NW]);
  assign qy_ext = XW'(dv_qy[NW]);
  assign limx   = fs.nx ? (XW'(1) << (OUT_BITS - 1)) : ((XW'(1) << (OUT_BITS - 1)) - 1'b1);
  assign limy   = fs.ny ? (XW'(1) << (OUT_BITS - 1)) : ((XW'(1) << (OUT_BITS - 1)) - 1'b1);

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    selx = qx_ext;
    sely = qy_ext;
    if (fs.mx == '0) begin
      selx = '0;
    end else if (dv_d[NW] == '0 || qx_ext > limx) begin
      satx = 1'b1;
      selx = limx;
    end
    if (fs.my == '0) begin
      sely = '0;
    end else if (dv_d[NW] == '0 || qy_ext > limy) begin
      saty = 1'b1;
      sely = limy;
    end
    px_nxt = fs.nx ? (~selx[OUT_BITS-1:0] + 1'b1) : selx[OUT_BITS-1:0];
    py_nxt = fs.ny ? (~sely[OUT_BITS-1:0] + 1'b1) : sely[OUT_BITS-1:0];
    if (fs.zero) begin
      st_nxt = ST_ZERO;
    end else if (fs.pole) begin
      st_nxt = ST_POLE;
    end else if (satx || saty) begin
      st_nxt = ST_SAT;
    end else begin
      st_nxt = ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plane_x_r <= px_nxt;
      plane_y_r <= py_nxt;
      status_r  <= st_nxt;
    end
  end

  assign out_if.valid   = out_v_r;
  assign out_if.plane_x = plane_x_r;
  assign out_if.plane_y = plane_y_r;
  assign out_if.status  = status_r;

  // checks
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (status_r == ST_ZERO || status_r == ST_POLE)
      |-> (plane_x_r == '0 && plane_y_r == '0))
    else $error("zero or pole word with nonzero coordinates");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v0_r)
    else $error("accepted word did not enter the pipeline");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_if.ready)
    else $error("input held off with an empty output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_if.ready |=> out_v_r && $stable(plane_x_r) && $stable(plane_y_r)
      && $stable(status_r))
    else $error("result word changed while stalled");

endmodule

### dv/stereographic_projection_checker.sv
`timescale 1ns / 1ps
// stereographic_projection_checker: watches both word channels, predicts each projection
// depends on stp_pkg, stp_in_if, stp_out_if

module stereographic_projection_checker
  import stp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  stp_in_if    in_w,
  stp_out_if   out_w,
  output int   mismatch_count,
  output int   pending_count,
  output int   result_count
);

  localparam int FRAC = OUT_FRAC_BITS_DEF;

  typedef struct {
    logic signed [OUT_BITS-1:0] plane_x;
    logic signed [OUT_BITS-1:0] plane_y;
    status_t                    status;
  } projection_t;

  projection_t projections_due[$];

  // floor square root of a 64-bit value, two bits per step
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [65:0] rem;
    logic [65:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | v[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // one projected component, truncated toward zero, clamped to 48 bits
  function automatic logic signed [OUT_BITS-1:0] plane_comp(
    input logic [63:0] mag, input bit neg, input logic [63:0] r8,
    input logic [63:0] d, inout bit sat);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] lim;
    lim = neg ? (128'd1 << (OUT_BITS - 1)) : ((128'd1 << (OUT_BITS - 1)) - 1);
    if (mag == 0) return '0;
    if (d == 0) begin
      sat = 1;
      q   = lim;
    end else begin
      num = ({64'd0, mag} * {64'd0, r8}) << FRAC;
      q   = num / {64'd0, d};
      if (q > lim) begin
        sat = 1;
        q   = lim;
      end
    end
    return neg ? -q[OUT_BITS-1:0] : q[OUT_BITS-1:0];
  endfunction

  function automatic projection_t project_point(
    input logic signed [15:0] px, input logic signed [15:0] py,
    input logic signed [15:0] pz);
    projection_t p;
    logic [63:0] mx, my, mz, s, r8, zs, d;
    bit sat;
    sat = 0;
    mx  = (px < 0) ? -64'(px) : 64'(px);
    my  = (py < 0) ? -64'(py) : 64'(py);
    mz  = (pz < 0) ? -64'(pz) : 64'(pz);
    p.plane_x = '0;
    p.plane_y = '0;
    if (mx == 0 && my == 0 && mz == 0) begin
      p.status = ST_ZERO;
      return p;
    end
    if (mx == 0 && my == 0 && pz >= 0) begin
      p.status = ST_POLE;
      return p;
    end
    s  = mx * mx + my * my + mz * mz;
    r8 = floor_sqrt(s << 16);
    zs = mz << 8;
    if (pz < 0) d = r8 + zs;
    else        d = (r8 >= zs) ? r8 - zs : 64'd0;
    p.plane_x = plane_comp(mx, px < 0, r8, d, sat);
    p.plane_y = plane_comp(my, py < 0, r8, d, sat);
    p.status  = sat ? ST_SAT : ST_NORMAL;
    return p;
  endfunction

  assign pending_count = projections_due.size();

  // predict on accepted input words, compare accepted result words
  always @(posedge clk) begin
    projection_t want;
    if (!rst_n) begin
      mismatch_count = 0;
      result_count   = 0;
    end else begin
      if (in_w.valid && in_w.ready)
        projections_due.push_back(project_point(in_w.px, in_w.py, in_w.pz));
      if (out_w.valid && out_w.ready) begin
        result_count++;
        if (projections_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word x=%0d y=%0d status=%0d",
                     out_w.plane_x, out_w.plane_y, out_w.status);
        end else begin
          want = projections_due.pop_front();
          if (want.plane_x !== out_w.plane_x || want.plane_y !== out_w.plane_y ||
              want.status !== out_w.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                       want.plane_x, want.plane_y, want.status,
                       out_w.plane_x, out_w.plane_y, out_w.status);
          end
        end
      end
    end
  end

endmodule

### dv/stereographic_projection_core_tb.sv
`timescale 1ns / 1ps
// stereographic_projection_core_tb: point stimulus, result back-pressure and verdict
// depends on stp_pkg, stp_in_if, stp_out_if, the core and the checker

module stereographic_projection_core_tb
  import stp_pkg::*;
;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_POINTS = 1580;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;
  int   result_count;
  int   points_sent;
  int   idle_cycles;
  bit   quiet;
  bit   hold_req;
  bit   stim_done;

  stp_in_if  in_w ();
  stp_out_if out_w ();

  stereographic_projection_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_w),
    .out_if (out_w)
  );

  stereographic_projection_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_w           (in_w),
    .out_w          (out_w),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .result_count   (result_count)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one point word, hold until taken, then idle a while
  task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] pz);
    int g;
    in_w.valid <= 1'b1;
    in_w.px    <= px;
    in_w.py    <= py;
    in_w.pz    <= pz;
    do @(posedge clk); while (!in_w.ready);
    points_sent++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_w.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_w.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // random point with a mix of shapes
  task automatic send_random_point();
    logic [15:0] px, py, pz;
    int kind;
    px = 16'($urandom);
    py = 16'($urandom);
    pz = 16'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        px = 16'($signed($urandom_range(0, 6)) - 3);
        py = 16'($signed($urandom_range(0, 6)) - 3);
        pz = 16'($urandom_range(1000, 32767));
      end
      1: begin
        px = 16'($signed($urandom_range(0, 40)) - 20);
        py = 16'($signed($urandom_range(0, 40)) - 20);
        pz = 16'($signed($urandom_range(0, 40)) - 20);
      end
      2: px = '0;
      3: py = '0;
      4: begin
        px = '0;
        py = '0;
      end
      default: ;
    endcase
    send_point(px, py, pz);
  endtask

  // result side: random ready, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken  = 0;
    out_w.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        out_w.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (quiet) begin
        out_w.ready <= 1'b1;
      end else begin
        out_w.ready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 3) begin
          out_w.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || stim_done && pending_count == 0 ||
        (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress, %0d results still due", pending_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    in_w.valid  = 1'b0;
    in_w.px     = '0;
    in_w.py     = '0;
    in_w.pz     = '0;
    rst_n       = 1'b0;
    points_sent = 0;
    quiet       = 0;
    hold_req    = 0;
    stim_done   = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: zero vector, north pole, far-out points, field extremes
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'd0, 16'd0, 16'd5);
    send_point(16'd0, 16'd0, 16'h7fff);
    send_point(16'd0, 16'd0, 16'hffff);
    send_point(16'd0, 16'd0, 16'h8000);
    send_point(16'd1, 16'd0, 16'h7fff);
    send_point(16'hffff, 16'd0, 16'h7fff);
    send_point(16'd0, 16'd1, 16'h7fff);
    send_point(16'd1, 16'hffff, 16'h7fff);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7fff, 16'd0);
    send_point(16'h7fff, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'd0, 16'd0);
    send_point(16'h8000, 16'd0, 16'd0);
    send_point(16'd1, 16'd1, 16'h8000);
    send_point(16'd1, 16'd0, 16'd0);
    send_point(16'd3, 16'd4, 16'd12);
    send_point(16'hfffd, 16'd4, 16'hfff4);
    send_point(16'd2, 16'd0, 16'h7ffe);
    wait_drained();

    // long hold on the result side while points keep coming
    quiet = 1;
    hold_req = 1;
    repeat (200) send_random_point();
    quiet = 0;
    wait_drained();
    repeat (5) @(negedge clk);

    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (i % 400 == 200) quiet = 1;
      if (i % 400 == 300) quiet = 0;
      if (i == 900) wait_drained();
      send_random_point();
    end
    in_w.valid <= 1'b0;
    stim_done = 1;

    while (pending_count != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    $display("sent %0d points (zero, pole, far-out and random), checked %0d results",
             points_sent, result_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/stp_pkg.sv
rtl/stp_in_if.sv
rtl/stp_out_if.sv
rtl/stereographic_projection_core.sv
dv/stereographic_projection_checker.sv
dv/stereographic_projection_core_tb.sv
